// File: hw/rtl/cmdas_pkg.sv
`default_nettype none

package cmdas_pkg;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  // Input selector codes.
  localparam logic FUNC_CHAR = 1'b0;
  localparam logic FUNC_EOL  = 1'b1;

  // Result kind codes.
  localparam logic KIND_RUN = 1'b0;
  localparam logic KIND_END = 1'b1;

  // One result: a run of a character, or an argument end.
  typedef struct packed {
    logic       kind;
    logic [7:0] out_char;
    logic [7:0] repeat_res;
  } res_t;

  // All results of one item. A single result always sits in r1.
  typedef struct packed {
    res_t       r0;
    res_t       r1;
    logic [1:0] n;
  } pair_t;

endpackage

`default_nettype wire

// File: hw/rtl/command_line_argument_splitter.sv
`default_nettype none

// Channel   Dir  Handshake                  Payload
// s_axis    in   tvalid/tready              tuser: func, tdata[7:0]: ch
// m_axis    out  tvalid/tready              tuser: kind, tdata: out_char, repeat_res;
//                                           tlast: last result of the item
//
// An accepted item waits in the input register until the buffer can take
// all its results; they are then formed in one pass and loaded into a
// two-entry result buffer. An item giving two results leaves through the
// single result port of the buffer one result at a time.
// Reset clears the input valid bit, the result count and the parsing state.
// The input side keeps accepting while results wait, as long as the buffer
// can drain its last entry in the same cycle the next item is loaded.

module command_line_argument_splitter
  import cmdas_pkg::*;
#(
  parameter int MAX_BACKSLASHES = 255
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] ch
  input  wire logic        s_axis_tuser_i,   // [0] func
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [15:0]      m_axis_tdata_o,   // [7:0] out_char, [15:8] repeat_res
  output logic             m_axis_tuser_o,   // [0] kind
  output logic             m_axis_tlast_o
);

  // Input register holding one accepted item.
  logic       in_v_q;
  logic       in_func_q;
  logic [7:0] in_ch_q;

  logic       can_load;
  logic       step;
  pair_t      pair;
  res_t       res;

  // The registered item moves on once the buffer can take all its results.
  assign step            = in_v_q && can_load;
  assign s_axis_tready_o = !in_v_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_v_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_func_q <= s_axis_tuser_i;
      in_ch_q   <= s_axis_tdata_i;
    end
  end

  // Parsing state and the result logic for one item.
  cmdas_core #(
    .MAX_BACKSLASHES(MAX_BACKSLASHES)
  ) u_core (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .step_i(step),
    .func_i(in_func_q),
    .ch_i  (in_ch_q),
    .pair_o(pair)
  );

  // Result buffer, delivering one result per cycle while the receiver is ready.
  cmdas_obuf u_obuf (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (step),
    .pair_i    (pair),
    .can_load_o(can_load),
    .valid_o   (m_axis_tvalid_o),
    .ready_i   (m_axis_tready_i),
    .res_o     (res),
    .last_o    (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {res.repeat_res, res.out_char};
  assign m_axis_tuser_o = res.kind;

endmodule

`default_nettype wire

// File: hw/rtl/cmdas_core.sv
`default_nettype none

module cmdas_core
  import cmdas_pkg::*;
#(
  parameter int MAX_BACKSLASHES = 255
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       step_i,
  input  wire logic       func_i,
  input  wire logic [7:0] ch_i,
  output pair_t           pair_o
);

  localparam logic [7:0] BsLimit =
      (MAX_BACKSLASHES > 255) ? 8'd255 : 8'(MAX_BACKSLASHES);

  logic       in_quote_q, in_quote_d;
  logic [7:0] pend_q, pend_d;
  logic       qp_q, qp_d;
  logic       arg_q, arg_d;

  logic       is_eol, is_sp, is_quote, is_bs;
  logic [7:0] a_rep;
  logic       a_v, b_v;
  res_t       res_a, res_b;

  always_comb begin
    is_eol   = (func_i == FUNC_EOL);
    is_sp    = !is_eol && !in_quote_q && (ch_i == CH_SPACE);
    is_quote = !is_eol && !is_sp && (ch_i == CH_QUOTE);
    is_bs    = !is_eol && !is_sp && (ch_i == CH_BSLASH);

    in_quote_d = in_quote_q;
    pend_d     = pend_q;
    qp_d       = qp_q;
    arg_d      = arg_q;

    // The pending backslash run is the first result, when it is not empty.
    if (is_eol) begin
      a_rep = in_quote_q ? 8'd0 : pend_q;
    end else if (is_quote) begin
      a_rep = pend_q >> 1;
    end else if (is_bs) begin
      a_rep = 8'd0;
    end else begin
      a_rep = pend_q;
    end
    a_v = (a_rep != 8'd0);
    res_a = '{kind: KIND_RUN, out_char: CH_BSLASH, repeat_res: a_rep};

    res_b = '{kind: KIND_RUN, out_char: ch_i, repeat_res: 8'd1};
    b_v   = 1'b0;

    if (is_eol || is_sp) begin
      // An argument ends if it held anything, counting the flushed run.
      res_b = '{kind: KIND_END, out_char: 8'd0, repeat_res: 8'd0};
      b_v   = arg_q || a_v;
      pend_d = 8'd0;
      arg_d  = 1'b0;
      if (is_eol) begin
        in_quote_d = 1'b0;
        qp_d       = 1'b0;
      end
    end else begin
      qp_d = is_quote ? !qp_q : 1'b0;
      if (is_bs) begin
        if (pend_q < BsLimit) begin
          pend_d = pend_q + 8'd1;
        end
      end else if (is_quote) begin
        pend_d = 8'd0;
        res_b  = '{kind: KIND_RUN, out_char: CH_QUOTE, repeat_res: 8'd1};
        if (pend_q[0]) begin
          b_v = 1'b1;
        end else if (!in_quote_q) begin
          in_quote_d = 1'b1;
          b_v        = !qp_d;
        end else begin
          in_quote_d = 1'b0;
        end
      end else begin
        pend_d = 8'd0;
        b_v    = 1'b1;
      end
      arg_d = arg_q || a_v || b_v;
    end

    pair_o.r0 = res_a;
    pair_o.r1 = b_v ? res_b : res_a;
    pair_o.n  = {1'b0, a_v} + {1'b0, b_v};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_quote_q <= 1'b0;
      pend_q     <= 8'd0;
      qp_q       <= 1'b0;
      arg_q      <= 1'b0;
    end else if (step_i) begin
      in_quote_q <= in_quote_d;
      pend_q     <= pend_d;
      qp_q       <= qp_d;
      arg_q      <= arg_d;
    end
  end

`ifndef SYNTHESIS
  a_eol_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (step_i && func_i == FUNC_EOL) |=> (pend_q == 8'd0 && !in_quote_q && !qp_q && !arg_q))
    else $error("state not cleared after end of line");

  a_pend_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
      pend_q <= BsLimit)
    else $error("backslash count above its limit");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/cmdas_obuf.sv
`default_nettype none

module cmdas_obuf
  import cmdas_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        load_i,
  input  wire pair_t       pair_i,
  output logic             can_load_o,
  output logic             valid_o,
  input  wire logic        ready_i,
  output res_t             res_o,
  output logic             last_o
);

  logic [1:0] cnt_q, cnt_d;
  res_t       slot0_q, slot1_q;
  logic       pop;

  assign pop        = valid_o && ready_i;
  assign valid_o    = (cnt_q != 2'd0);
  assign can_load_o = (cnt_q == 2'd0) || (cnt_q == 2'd1 && ready_i);
  // With two results queued the first one shows; the last one is in slot 1.
  assign res_o      = (cnt_q == 2'd2) ? slot0_q : slot1_q;
  assign last_o     = (cnt_q == 2'd1);

  always_comb begin
    cnt_d = cnt_q;
    if (load_i) begin
      cnt_d = pair_i.n;
    end else if (pop) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      slot0_q <= pair_i.r0;
      slot1_q <= pair_i.r1;
    end
  end

`ifndef SYNTHESIS
  a_load_safe: assert property (@(posedge clk_i) disable iff (!rst_ni)
      load_i |-> (cnt_q == 2'd0 || (cnt_q == 2'd1 && pop)))
    else $error("results loaded over undelivered ones");

  a_pop_two: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (cnt_q == 2'd2 && pop) |=> (cnt_q == 2'd1))
    else $error("second result lost after first was taken");
`endif

endmodule

`default_nettype wire

// File: test/command_line_argument_splitter_tb.sv
module command_line_argument_splitter_tb;
  import cmdas_pkg::*;

  localparam int MAX_BS       = 255;
  localparam int BS_CAP       = (MAX_BS > 255) ? 255 : MAX_BS;
  localparam int ITEMS_PHASE  = 70;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 6;
  localparam int STALL_LIMIT  = 4000;

  // One character or end-of-line item as offered on the input stream.
  typedef struct packed {
    logic       func;
    logic [7:0] ch;
  } char_item_t;

  // One piece of argument text, or an argument end, as seen on the output.
  typedef struct packed {
    logic       kind;
    logic [7:0] ch;
    logic [7:0] count;
    logic       last;
  } arg_piece_t;

  logic        clk_i = 1'b0;
  logic        rst_n = 1'b0;
  logic        s_valid = 1'b0;
  logic [7:0]  s_ch = 8'h00;
  logic        s_func = FUNC_CHAR;
  logic        m_ready = 1'b0;
  logic        s_took = 1'b0;
  wire         s_ready;
  wire         m_valid;
  wire  [15:0] m_data;
  wire         m_kind;
  wire         m_last;

  char_item_t  pending_chars[$];
  arg_piece_t  expected_pieces[$];
  arg_piece_t  step_pieces[$];

  // Splitter state as the predictor tracks it.
  logic        quoted;
  logic [7:0]  bs_run;
  logic        quote_odd;
  logic        arg_open;

  int          src_idle_pct = 7;
  int          sink_idle_pct = 46;
  int          hold_token = 0;
  int          hold_seen = 0;
  int          hold_left = 0;
  int          n_queued = 0;
  int          n_accepted = 0;
  int          n_results = 0;
  int          n_arg_ends = 0;
  int          n_saturated = 0;
  int          n_mismatch = 0;
  int          quiet_cycles = 0;

  command_line_argument_splitter #(
    .MAX_BACKSLASHES(MAX_BS)
  ) i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_ch),
    .s_axis_tuser_i  (s_func),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tuser_o  (m_kind),
    .m_axis_tlast_o  (m_last)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  task automatic add_piece(input logic kind, input logic [7:0] c, input logic [7:0] rep);
    arg_piece_t p;
    // A run of zero copies produces nothing.
    if (kind == KIND_RUN && rep == 8'd0) begin
      return;
    end
    p = '{kind, c, rep, 1'b0};
    step_pieces.push_back(p);
    if (kind == KIND_RUN) begin
      arg_open = 1'b1;
    end else begin
      n_arg_ends++;
    end
  endtask

  task automatic flush_backslashes();
    add_piece(KIND_RUN, CH_BSLASH, bs_run);
    bs_run = 8'd0;
  endtask

  task automatic clear_split_state();
    quoted    = 1'b0;
    bs_run    = 8'd0;
    quote_odd = 1'b0;
    arg_open  = 1'b0;
  endtask

  task automatic split_char(input logic func, input logic [7:0] c);
    logic [7:0] cnt;
    arg_piece_t p;
    step_pieces.delete();
    if (func == FUNC_EOL) begin
      // Backslashes still pending inside quotes are lost at end of line.
      if (!quoted) begin
        flush_backslashes();
      end
      if (arg_open) begin
        add_piece(KIND_END, 8'h00, 8'd0);
      end
      clear_split_state();
    end else if (!quoted && c == CH_SPACE) begin
      flush_backslashes();
      if (arg_open) begin
        add_piece(KIND_END, 8'h00, 8'd0);
        arg_open = 1'b0;
      end
    end else begin
      // Unquoted spaces never reach here, so they leave the quote run alone.
      if (c == CH_QUOTE) begin
        quote_odd = ~quote_odd;
      end else begin
        quote_odd = 1'b0;
      end
      if (c == CH_BSLASH) begin
        if (bs_run < BS_CAP) begin
          bs_run = bs_run + 8'd1;
        end else begin
          n_saturated++;
        end
      end else if (c == CH_QUOTE) begin
        cnt = bs_run;
        bs_run = 8'd0;
        if (!cnt[0]) begin
          add_piece(KIND_RUN, CH_BSLASH, cnt >> 1);
          if (!quoted) begin
            quoted = 1'b1;
            // An opening quote that ends an even run of quotes is literal.
            if (!quote_odd) begin
              add_piece(KIND_RUN, CH_QUOTE, 8'd1);
            end
          end else begin
            quoted = 1'b0;
          end
        end else begin
          add_piece(KIND_RUN, CH_BSLASH, (cnt - 8'd1) >> 1);
          add_piece(KIND_RUN, CH_QUOTE, 8'd1);
        end
      end else begin
        flush_backslashes();
        add_piece(KIND_RUN, c, 8'd1);
      end
    end
    if (step_pieces.size() != 0) begin
      step_pieces[step_pieces.size() - 1].last = 1'b1;
    end
    while (step_pieces.size() != 0) begin
      p = step_pieces.pop_front();
      expected_pieces.push_back(p);
    end
  endtask

  task automatic note_mismatch(input string what, input arg_piece_t want, input arg_piece_t got);
    n_mismatch++;
    if (n_mismatch <= 10) begin
      $display("%s: expected kind=%0d char=%02h count=%0d last=%0d,",
               what, want.kind, want.ch, want.count, want.last);
      $display("  got kind=%0d char=%02h count=%0d last=%0d",
               got.kind, got.ch, got.count, got.last);
    end
  endtask

  // ---------------------------------------------------------------------
  // Monitor: input acceptance feeds the predictor, output acceptance is
  // compared against the oldest expected piece.
  // ---------------------------------------------------------------------

  always @(posedge clk_i) begin
    arg_piece_t got;
    arg_piece_t want;
    s_took <= s_valid && s_ready;
    if (s_valid && s_ready) begin
      split_char(s_func, s_ch);
      n_accepted++;
    end
    if (m_valid && m_ready) begin
      got = '{m_kind, m_data[7:0], m_data[15:8], m_last};
      n_results++;
      if (expected_pieces.size() == 0) begin
        note_mismatch("unexpected result", '0, got);
      end else begin
        want = expected_pieces.pop_front();
        if (got !== want) begin
          note_mismatch("wrong result", want, got);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_valid && s_ready) || (m_valid && m_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", quiet_cycles);
      $display("command_line_argument_splitter_tb: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Driver and receiver, both acting on the falling edge.
  // ---------------------------------------------------------------------

  always @(negedge clk_i) begin
    char_item_t nxt;
    if (!rst_n) begin
      s_valid <= 1'b0;
    end else if (!s_valid || s_took) begin
      if (pending_chars.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        nxt = pending_chars.pop_front();
        s_func  <= nxt.func;
        s_ch    <= nxt.ch;
        s_valid <= 1'b1;
      end else begin
        s_valid <= 1'b0;
      end
    end
  end

  // A new hold token makes the receiver back off for a long stretch while
  // the driver keeps offering items, so the block has to stall its input.
  always @(negedge clk_i) begin
    if (hold_seen != hold_token) begin
      hold_seen <= hold_token;
      hold_left <= HOLD_CYCLES;
      m_ready   <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_ready   <= 1'b0;
    end else begin
      m_ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------

  task automatic queue_char(input logic [7:0] c);
    pending_chars.push_back(char_item_t'{FUNC_CHAR, c});
    n_queued++;
  endtask

  task automatic queue_eol();
    // The character field is ignored on end of line, so it carries noise.
    pending_chars.push_back(char_item_t'{FUNC_EOL, 8'($urandom_range(255))});
    n_queued++;
  endtask

  task automatic queue_line();
    int tokens;
    int pick;
    int run;
    tokens = $urandom_range(12, 1);
    for (int t = 0; t < tokens; t++) begin
      pick = $urandom_range(99);
      if (pick < 25) begin
        run = $urandom_range(5, 1);
        repeat (run) queue_char(CH_BSLASH);
      end else if (pick < 45) begin
        queue_char(CH_QUOTE);
      end else if (pick < 60) begin
        queue_char(CH_SPACE);
      end else if (pick < 85) begin
        queue_char(8'h61 + 8'($urandom_range(25)));
      end else if (pick < 96) begin
        queue_char(8'($urandom_range(255)));
      end else begin
        queue_eol();
      end
    end
    queue_eol();
  endtask

  task automatic queue_lines(input int count);
    int target;
    target = n_queued + count;
    while (n_queued < target) begin
      queue_line();
    end
  endtask

  // Waits until every queued item is taken and every expected piece has
  // arrived, then keeps clocking so items that produce nothing settle.
  task automatic drain();
    while (n_accepted != n_queued || expected_pieces.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    clear_split_state();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // Plain characters, including the extreme codes and a newline code.
    queue_char(8'h61);
    queue_char(8'h00);
    queue_char(8'hFF);
    queue_char(8'h0A);
    queue_char(CH_SPACE);
    // Two backslashes open quotes and give one backslash.
    queue_char(CH_BSLASH);
    queue_char(CH_BSLASH);
    queue_char(CH_QUOTE);
    queue_char(CH_SPACE);
    // Three backslashes give one backslash and a literal quote.
    queue_char(CH_BSLASH);
    queue_char(CH_BSLASH);
    queue_char(CH_BSLASH);
    queue_char(CH_QUOTE);
    // Close, then reopen at an even quote run: a literal quote.
    queue_char(8'h71);
    queue_char(CH_QUOTE);
    queue_char(CH_QUOTE);
    // Pending backslash dropped at end of line inside quotes.
    queue_char(CH_BSLASH);
    queue_eol();
    // A lone pair of quotes is an empty argument and never reported.
    queue_char(CH_QUOTE);
    queue_char(CH_QUOTE);
    queue_char(CH_SPACE);
    // Pending backslashes emitted at end of line outside quotes.
    queue_char(CH_BSLASH);
    queue_char(CH_BSLASH);
    queue_eol();
    queue_eol();
    drain();

    // Sender idles rarely, receiver often. A saturated backslash run comes
    // first and is flushed whole by a letter.
    repeat (256) queue_char(CH_BSLASH);
    queue_char(8'h7A);
    queue_eol();
    queue_lines(ITEMS_PHASE);
    drain();

    src_idle_pct  = 46;
    sink_idle_pct = 7;
    queue_lines(ITEMS_PHASE);
    drain();

    src_idle_pct  = 0;
    sink_idle_pct = 0;
    hold_token++;
    queue_lines(ITEMS_PHASE);
    drain();

    repeat (20) @(posedge clk_i);
    $display("Run covered %0d items and %0d results, %0d of them argument ends,",
             n_accepted, n_results, n_arg_ends);
    $display("with %0d backslashes dropped at saturation and three pacing phases.",
             n_saturated);
    if (n_mismatch == 0 && expected_pieces.size() == 0) begin
      $display("command_line_argument_splitter_tb: PASS");
    end else begin
      $display("%0d mismatches, %0d results missing", n_mismatch, expected_pieces.size());
      $display("command_line_argument_splitter_tb: FAIL");
    end
    $finish;
  end

endmodule
